@@ rtl/sbac_pkg.sv @@
package sbac_pkg;

  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 17;
  localparam int FUNC_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int BYTE_W    = 8;
  localparam int ENTRY_W   = ADDR_W + LEN_W;

  localparam logic [BYTE_W-1:0] FULL_MASK = 8'hFF;
  localparam logic [2:0]        TOP_BIT   = 3'd7;

  localparam logic [FUNC_W-1:0] FUNC_CHECK       = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_MARK_VALID  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_MARK_POISON = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RECORD      = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END    = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAB_RD,
    ST_TAB_CMP,
    ST_PREP,
    ST_CLIP,
    ST_MAP_RD,
    ST_MAP_WR,
    ST_DONE
  } state_t;

endpackage

@@ rtl/sbac_ifs.sv @@
interface sbac_item_if;
  logic                              valid;
  logic                              ready;
  logic [sbac_pkg::FUNC_W-1:0]       func;
  logic                              store;
  logic [sbac_pkg::ADDR_W-1:0]       addr;
  logic [sbac_pkg::LEN_W-1:0]        length;

  modport source (output valid, func, store, addr, length, input ready);
  modport sink (input valid, func, store, addr, length, output ready);
endinterface

interface sbac_result_if;
  logic                              valid;
  logic                              ready;
  logic                              access_ok;
  logic                              report_write;
  logic [sbac_pkg::ADDR_W-1:0]       report_addr;
  logic [sbac_pkg::LEN_W-1:0]        report_length;
  logic                              slot_found;

  modport source (output valid, access_ok, report_write, report_addr, report_length,
                  slot_found, input ready);
  modport sink (input valid, access_ok, report_write, report_addr, report_length,
                slot_found, output ready);
endinterface

@@ rtl/sbac_ram.sv @@
module sbac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/shadow_bitmap_access_checker.sv @@
// channel  dir  payload                                                 transaction
// item     in   func, store, addr, length                               valid && ready
// result   out  access_ok, report_write, report_addr, report_length,    valid && ready
//               slot_found
// cfg      in   cfg_index, cfg_data                                     cfg_we
//
// one item at a time: a check or mark reads each shadow byte walked, and a mark writes it
// back (the shadow ram has one read port and one write port). nothing is walked when the start
// is outside the window or the length is zero. record/release first scan the table slot by
// slot; a miss scans the whole table. a disabled check, zero address or unused func goes
// straight to the result.
// after reset a clearing pass zeroes both rams; item.ready stays low meanwhile. a stalled
// result holds the block in its last step.
module shadow_bitmap_access_checker #(
  parameter int WINDOW_BYTES  = 65536,
  parameter int TABLE_ENTRIES = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sbac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbac_pkg::ADDR_W-1:0]      cfg_data,
  sbac_item_if.sink                        item,
  sbac_result_if.source                    result
);

  localparam int MAP_DEPTH = (WINDOW_BYTES + 7) / 8;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int OFF_W     = $clog2(WINDOW_BYTES);
  localparam int TAB_AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CLR_DEPTH = (MAP_DEPTH > TABLE_ENTRIES) ? MAP_DEPTH : TABLE_ENTRIES;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int AW        = sbac_pkg::ADDR_W;
  localparam int LW        = sbac_pkg::LEN_W;
  localparam logic [AW:0]        WIN_SPAN  = (AW+1)'(WINDOW_BYTES - 1);
  localparam logic [AW:0]        WIN_SIZE  = (AW+1)'(WINDOW_BYTES);
  localparam logic [TAB_AW-1:0]  TAB_LAST  = TAB_AW'(TABLE_ENTRIES - 1);
  localparam logic [CLR_W-1:0]   CLR_LAST  = CLR_W'(CLR_DEPTH - 1);

  sbac_pkg::state_t state, state_next;

  logic                          enable;
  logic [AW-1:0]                 window_base;
  logic [AW-1:0]                 window_end;

  logic [sbac_pkg::FUNC_W-1:0]   req_func;
  logic                          req_write;
  logic [AW-1:0]                 req_addr;
  logic [LW-1:0]                 req_length;
  logic [LW-1:0]                 rng_len;
  logic                          ok;
  logic                          found;
  logic [TAB_AW-1:0]             tab_idx;
  logic [CLR_W-1:0]              clr_cnt;
  logic [AW:0]                   limit;
  logic [OFF_W-1:0]              first_off;
  logic [OFF_W-1:0]              last_off;
  logic [MAP_AW-1:0]             word;

  logic                          map_we;
  logic [MAP_AW-1:0]             map_waddr;
  logic [sbac_pkg::BYTE_W-1:0]   map_wdata;
  logic [sbac_pkg::BYTE_W-1:0]   map_rdata;
  logic                          tab_we;
  logic [TAB_AW-1:0]             tab_waddr;
  logic [sbac_pkg::ENTRY_W-1:0]  tab_wdata;
  logic [sbac_pkg::ENTRY_W-1:0]  tab_rdata;

  logic                          poison;
  logic                          in_window;
  logic [AW-1:0]                 start_diff;
  logic [AW:0]                   limit_c;
  logic [AW:0]                   end_c;
  logic [AW:0]                   last_c;
  logic [AW:0]                   last_diff;
  logic [2:0]                    lo_bit;
  logic [2:0]                    hi_bit;
  logic [sbac_pkg::BYTE_W-1:0]   mask;
  logic                          last_word;
  logic                          hit;
  logic                          tab_match;
  logic [AW-1:0]                 ent_start;
  logic [LW-1:0]                 ent_len;
  logic                          out_load;

  sbac_ram #(.WIDTH(sbac_pkg::BYTE_W), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (word),
    .rdata (map_rdata)
  );

  sbac_ram #(.WIDTH(sbac_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_idx),
    .rdata (tab_rdata)
  );

  // window and clipping arithmetic
  assign poison     = (req_func == sbac_pkg::FUNC_MARK_POISON) ||
                      (req_func == sbac_pkg::FUNC_RELEASE);
  assign start_diff = req_addr - window_base;
  assign in_window  = (req_addr >= window_base) && (req_addr <= window_end) &&
                      ({1'b0, start_diff} < WIN_SIZE);
  assign limit_c    = {1'b0, window_base} + WIN_SPAN;
  assign end_c      = {1'b0, req_addr} + (AW+1)'(rng_len) - (AW+1)'(1);
  assign last_c     = (end_c < limit) ? end_c : limit;
  assign last_diff  = last_c - {1'b0, window_base};

  // per shadow byte mask
  assign lo_bit    = (word == first_off[OFF_W-1:3]) ? first_off[2:0] : 3'd0;
  assign hi_bit    = (word == last_off[OFF_W-1:3]) ? last_off[2:0] : sbac_pkg::TOP_BIT;
  assign mask      = (sbac_pkg::FULL_MASK << lo_bit) &
                     (sbac_pkg::FULL_MASK >> (sbac_pkg::TOP_BIT - hi_bit));
  assign last_word = (word == last_off[OFF_W-1:3]);
  assign hit       = (map_rdata & mask) != '0;

  assign ent_start = tab_rdata[sbac_pkg::ENTRY_W-1:LW];
  assign ent_len   = tab_rdata[LW-1:0];
  assign tab_match = (req_func == sbac_pkg::FUNC_RECORD) ? (ent_start == '0)
                                                         : (ent_start == req_addr);

  assign out_load  = (state == sbac_pkg::ST_DONE) && (!result.valid || result.ready);

  always_comb begin
    state_next = state;
    case (state)
      sbac_pkg::ST_CLEAR: begin
        if (clr_cnt == CLR_LAST) state_next = sbac_pkg::ST_IDLE;
      end
      sbac_pkg::ST_IDLE: begin
        if (item.valid) begin
          case (item.func)
            sbac_pkg::FUNC_CHECK:
              state_next = enable ? sbac_pkg::ST_PREP : sbac_pkg::ST_DONE;
            sbac_pkg::FUNC_MARK_VALID, sbac_pkg::FUNC_MARK_POISON:
              state_next = sbac_pkg::ST_PREP;
            sbac_pkg::FUNC_RECORD, sbac_pkg::FUNC_RELEASE:
              state_next = (item.addr != '0) ? sbac_pkg::ST_TAB_RD : sbac_pkg::ST_DONE;
            default:
              state_next = sbac_pkg::ST_DONE;
          endcase
        end
      end
      sbac_pkg::ST_TAB_RD: state_next = sbac_pkg::ST_TAB_CMP;
      sbac_pkg::ST_TAB_CMP: begin
        if (tab_match) state_next = sbac_pkg::ST_PREP;
        else if (tab_idx == TAB_LAST) state_next = sbac_pkg::ST_DONE;
        else state_next = sbac_pkg::ST_TAB_RD;
      end
      sbac_pkg::ST_PREP: begin
        state_next = (in_window && rng_len != '0) ? sbac_pkg::ST_CLIP : sbac_pkg::ST_DONE;
      end
      sbac_pkg::ST_CLIP: state_next = sbac_pkg::ST_MAP_RD;
      sbac_pkg::ST_MAP_RD: state_next = sbac_pkg::ST_MAP_WR;
      sbac_pkg::ST_MAP_WR: begin
        if ((req_func == sbac_pkg::FUNC_CHECK && hit) || last_word) begin
          state_next = sbac_pkg::ST_DONE;
        end else begin
          state_next = sbac_pkg::ST_MAP_RD;
        end
      end
      sbac_pkg::ST_DONE: begin
        if (out_load) state_next = sbac_pkg::ST_IDLE;
      end
      default: state_next = sbac_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    item.ready = 1'b0;
    map_we     = 1'b0;
    map_waddr  = word;
    map_wdata  = poison ? (map_rdata | mask) : (map_rdata & ~mask);
    tab_we     = 1'b0;
    tab_waddr  = tab_idx;
    tab_wdata  = '0;
    case (state)
      sbac_pkg::ST_CLEAR: begin
        map_waddr = clr_cnt[MAP_AW-1:0];
        map_wdata = '0;
        map_we    = ({1'b0, clr_cnt} < (CLR_W+1)'(MAP_DEPTH));
        tab_waddr = clr_cnt[TAB_AW-1:0];
        tab_we    = ({1'b0, clr_cnt} < (CLR_W+1)'(TABLE_ENTRIES));
      end
      sbac_pkg::ST_IDLE: item.ready = 1'b1;
      sbac_pkg::ST_TAB_CMP: begin
        tab_we = tab_match;
        if (req_func == sbac_pkg::FUNC_RECORD) tab_wdata = {req_addr, req_length};
      end
      sbac_pkg::ST_MAP_WR: map_we = (req_func != sbac_pkg::FUNC_CHECK);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sbac_pkg::ST_CLEAR;
      enable      <= 1'b0;
      window_base <= '0;
      window_end  <= '0;
      clr_cnt     <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          sbac_pkg::CFG_ENABLE: enable      <= cfg_data[0];
          sbac_pkg::CFG_BASE:   window_base <= cfg_data;
          sbac_pkg::CFG_END:    window_end  <= cfg_data;
          default: ;
        endcase
      end
      if (state == sbac_pkg::ST_CLEAR) clr_cnt <= clr_cnt + CLR_W'(1);
      if (out_load) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sbac_pkg::ST_IDLE: begin
        req_func   <= item.func;
        req_write  <= item.store;
        req_addr   <= item.addr;
        req_length <= item.length;
        rng_len    <= item.length;
        ok         <= 1'b1;
        found      <= 1'b0;
        tab_idx    <= '0;
      end
      sbac_pkg::ST_TAB_CMP: begin
        if (tab_match) begin
          found <= 1'b1;
          if (req_func == sbac_pkg::FUNC_RELEASE) rng_len <= ent_len;
        end else begin
          tab_idx <= tab_idx + TAB_AW'(1);
        end
      end
      sbac_pkg::ST_PREP: begin
        limit     <= (limit_c < {1'b0, window_end}) ? limit_c : {1'b0, window_end};
        first_off <= start_diff[OFF_W-1:0];
      end
      sbac_pkg::ST_CLIP: begin
        last_off <= last_diff[OFF_W-1:0];
        word     <= first_off[OFF_W-1:3];
      end
      sbac_pkg::ST_MAP_WR: begin
        if (req_func == sbac_pkg::FUNC_CHECK && hit) ok <= 1'b0;
        word <= word + MAP_AW'(1);
      end
      default: ;
    endcase
    if (out_load) begin
      result.access_ok     <= ok;
      result.report_write  <= req_write;
      result.report_addr   <= req_addr;
      result.report_length <= req_length;
      result.slot_found    <= found;
    end
  end

endmodule

@@ rtl/sbac_checker.sv @@
module sbac_checker (
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_ready,
  input logic result_valid,
  input logic result_ready,
  input logic access_ok,
  input logic slot_found
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("stalled result dropped");

  a_fail_no_slot: assert property (@(posedge clk) disable iff (rst)
    result_valid && !access_ok |-> !slot_found)
    else $error("failed check reports a slot");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second transaction taken while busy");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !$rose(result_valid))
    else $error("result rose in the cycle after accept");

endmodule

bind shadow_bitmap_access_checker sbac_checker u_sbac_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .access_ok    (result.access_ok),
  .slot_found   (result.slot_found)
);
